/* sv/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, status codes, cell payload types, the division step function
// and the root formatting function for the quadratic root solver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // discriminant: signed difference width and radicand width
  localparam int DS_W   = 2 * WORD_BITS + 3;
  localparam int D_W    = 2 * WORD_BITS + 4;
  localparam int ROOT_W = D_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  // divider operands
  localparam int DEN_W  = WORD_BITS + 1;
  localparam int NUM_W  = ROOT_W + 2;
  localparam int DREM_W = DEN_W + 1;
  localparam int DIVD_W = NUM_W - 1 + FRAC_BITS;
  localparam int QK_W   = WORD_BITS + 1;

  localparam int SQ_CELLS  = ROOT_W;
  localparam int DIV_CELLS = DIVD_W;

  localparam logic [1:0] ST_TWO  = 2'd0;
  localparam logic [1:0] ST_ONE  = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic [D_W-1:0]    d;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [DEN_W-1:0]  num_base;
    logic [DEN_W-1:0]  den;
  } sq_t;

  typedef struct packed {
    logic              neg;
    logic [DIVD_W-1:0] nd;
    logic [DREM_W-1:0] rem;
    logic [QK_W-1:0]   q;
    logic              big;
  } lane_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       status;
    logic [DEN_W-1:0] dm;
    lane_t            p;
    lane_t            m;
  } dv_t;

  typedef struct packed {
    logic                 ovf;
    logic [WORD_BITS-1:0] val;
  } root_t;

  // one restoring quotient bit
  function automatic lane_t div_lane(lane_t l, logic [DEN_W-1:0] dm);
    logic [DREM_W-1:0] r2;
    logic [DREM_W-1:0] dmx;
    lane_t             o;
    o     = l;
    dmx   = {1'b0, dm};
    r2    = {l.rem[DREM_W-2:0], l.nd[DIVD_W-1]};
    o.nd  = {l.nd[DIVD_W-2:0], 1'b0};
    o.big = l.big | l.q[QK_W-1];
    if (r2 >= dmx) begin
      o.rem = r2 - dmx;
      o.q   = {l.q[QK_W-2:0], 1'b1};
    end else begin
      o.rem = r2;
      o.q   = {l.q[QK_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // apply sign and saturate to the word range
  function automatic root_t fmt_root(lane_t l);
    logic  sat_pos;
    logic  sat_neg;
    root_t r;
    sat_pos = l.big | l.q[QK_W-1] | l.q[QK_W-2];
    sat_neg = l.big | l.q[QK_W-1] | (l.q[QK_W-2] & (|l.q[QK_W-3:0]));
    if (l.neg) begin
      r.ovf = sat_neg;
      r.val = sat_neg ? {1'b1, {(WORD_BITS-1){1'b0}}}
                      : ({WORD_BITS{1'b0}} - l.q[WORD_BITS-1:0]);
    end else begin
      r.ovf = sat_pos;
      r.val = sat_pos ? {1'b0, {(WORD_BITS-1){1'b1}}} : l.q[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/qrs_front.sv */
// ----------------------------------------------------------------------------
// qrs_front
// Two registered stages: coefficient products, then the exact discriminant,
// case split and seed for the square root chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qrs_front (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  en,
  input  wire                                  in_valid,
  input  wire logic signed [qrs_pkg::WORD_BITS-1:0] coef_a,
  input  wire logic signed [qrs_pkg::WORD_BITS-1:0] coef_b,
  input  wire logic signed [qrs_pkg::WORD_BITS-1:0] coef_c,
  output qrs_pkg::sq_t                         sq_o
);

  localparam int W = qrs_pkg::WORD_BITS;

  logic                  v1_r;
  logic [W-1:0]          a1_r, b1_r, c1_r;
  logic signed [2*W-1:0] bb_r, ac_r;
  logic signed [2*W-1:0] bb_nxt, ac_nxt;

  logic [qrs_pkg::DS_W-1:0] p_ext, q4, dsig;
  qrs_pkg::sq_t             sq_nxt, sq_r;

  assign bb_nxt = coef_b * coef_b;
  assign ac_nxt = coef_a * coef_c;

  always_comb begin
    p_ext         = {3'b000, bb_r};
    q4            = {ac_r[2*W-1], ac_r, 2'b00};
    dsig          = p_ext - q4;
    sq_nxt        = '0;
    sq_nxt.valid  = v1_r;
    if (a1_r == '0) begin
      sq_nxt.status   = (b1_r == '0) ? qrs_pkg::ST_ERR : qrs_pkg::ST_ONE;
      sq_nxt.num_base = {qrs_pkg::DEN_W{1'b0}} - {c1_r[W-1], c1_r};
      sq_nxt.den      = {b1_r[W-1], b1_r};
    end else begin
      sq_nxt.num_base = {qrs_pkg::DEN_W{1'b0}} - {b1_r[W-1], b1_r};
      sq_nxt.den      = {a1_r, 1'b0};
      if (dsig[qrs_pkg::DS_W-1]) begin
        sq_nxt.status = qrs_pkg::ST_NONE;
      end else if (dsig == '0) begin
        sq_nxt.status = qrs_pkg::ST_ONE;
      end else begin
        sq_nxt.status = qrs_pkg::ST_TWO;
        sq_nxt.d      = {{(qrs_pkg::D_W-qrs_pkg::DS_W){1'b0}}, dsig};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      sq_r.valid <= 1'b0;
    end else if (en) begin
      v1_r       <= in_valid;
      sq_r.valid <= sq_nxt.valid;
    end
    if (en) begin
      a1_r <= coef_a;
      b1_r <= coef_b;
      c1_r <= coef_c;
      bb_r <= bb_nxt;
      ac_r <= ac_nxt;
      sq_r.status   <= sq_nxt.status;
      sq_r.d        <= sq_nxt.d;
      sq_r.rem      <= sq_nxt.rem;
      sq_r.root     <= sq_nxt.root;
      sq_r.num_base <= sq_nxt.num_base;
      sq_r.den      <= sq_nxt.den;
    end
  end

  assign sq_o = sq_r;

endmodule

`default_nettype wire

/* sv/qrs_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit-by-digit square root step: brings down two radicand bits and
// settles one root bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qrs_sqrt_cell (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               en,
  input  wire qrs_pkg::sq_t sq_i,
  output qrs_pkg::sq_t      sq_o
);

  logic [qrs_pkg::REM_W-1:0] rem2, trial;
  qrs_pkg::sq_t              sq_nxt, sq_r;

  always_comb begin
    sq_nxt = sq_i;
    rem2   = {sq_i.rem[qrs_pkg::REM_W-3:0], sq_i.d[qrs_pkg::D_W-1 -: 2]};
    trial  = {sq_i.root, 2'b01};
    sq_nxt.d = {sq_i.d[qrs_pkg::D_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      sq_nxt.rem  = rem2 - trial;
      sq_nxt.root = {sq_i.root[qrs_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      sq_nxt.rem  = rem2;
      sq_nxt.root = {sq_i.root[qrs_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r.valid <= 1'b0;
    end else if (en) begin
      sq_r.valid <= sq_nxt.valid;
    end
    if (en) begin
      sq_r.status   <= sq_nxt.status;
      sq_r.d        <= sq_nxt.d;
      sq_r.rem      <= sq_nxt.rem;
      sq_r.root     <= sq_nxt.root;
      sq_r.num_base <= sq_nxt.num_base;
      sq_r.den      <= sq_nxt.den;
    end
  end

  assign sq_o = sq_r;

endmodule

`default_nettype wire

/* sv/qrs_div_cell.sv */
// ----------------------------------------------------------------------------
// qrs_div_cell
// One restoring division step for both roots, sharing the divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qrs_div_cell (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               en,
  input  wire qrs_pkg::dv_t dv_i,
  output qrs_pkg::dv_t      dv_o
);

  qrs_pkg::dv_t dv_nxt, dv_r;

  always_comb begin
    dv_nxt   = dv_i;
    dv_nxt.p = qrs_pkg::div_lane(dv_i.p, dv_i.dm);
    dv_nxt.m = qrs_pkg::div_lane(dv_i.m, dv_i.dm);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r.valid <= 1'b0;
    end else if (en) begin
      dv_r.valid <= dv_nxt.valid;
    end
    if (en) begin
      dv_r.status <= dv_nxt.status;
      dv_r.dm     <= dv_nxt.dm;
      dv_r.p      <= dv_nxt.p;
      dv_r.m      <= dv_nxt.m;
    end
  end

  assign dv_o = dv_r;

endmodule

`default_nettype wire

/* sv/quadratic_root_solver_unit.sv */
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// Real roots of a*x^2 + b*x + c = 0 in signed Q16.16, truncated toward zero.
// ----------------------------------------------------------------------------
// Input channel in_*: one coefficient set (a, b, c) per beat.
// Output channel out_*: one result per beat: status, root_plus, root_minus,
// overflow. Results leave in input order.
// The path from an accepted beat to out_valid is two front stages (products,
// discriminant), 34 square root cells (one root bit each), one numerator stage,
// 51 division cells (one quotient bit each) and the write into the output
// buffer.
// Throughput: one beat per cycle while in_ready is high; every stage is a
// register stage. The results land in a two-entry output buffer. in_ready
// is low only while that buffer is full; the whole cell row then holds. With
// one result waiting, new beats are still taken.
// Reset (rst_n low, synchronous) clears every valid bit and empties the
// buffer; stored coefficients and data fields are left as they were.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quadratic_root_solver_unit (
  input  wire                                       clk,
  input  wire                                       rst_n,
  input  wire                                       in_valid,
  output logic                                      in_ready,
  input  wire logic signed [qrs_pkg::WORD_BITS-1:0] in_coef_a,
  input  wire logic signed [qrs_pkg::WORD_BITS-1:0] in_coef_b,
  input  wire logic signed [qrs_pkg::WORD_BITS-1:0] in_coef_c,
  output logic                                      out_valid,
  input  wire                                       out_ready,
  output logic [1:0]                                out_status,
  output logic signed [qrs_pkg::WORD_BITS-1:0]      out_root_plus,
  output logic signed [qrs_pkg::WORD_BITS-1:0]      out_root_minus,
  output logic                                      out_overflow
);

  localparam int W = qrs_pkg::WORD_BITS;

  typedef struct packed {
    logic [1:0]   status;
    logic [W-1:0] rp;
    logic [W-1:0] rm;
    logic         ovf;
  } res_t;

  logic en;

  qrs_pkg::sq_t sq_chain [0:qrs_pkg::SQ_CELLS];
  qrs_pkg::dv_t dv_chain [0:qrs_pkg::DIV_CELLS];
  qrs_pkg::dv_t prep_nxt, prep_r;

  logic [qrs_pkg::NUM_W-1:0] nb_ext, np, nm, mag_p, mag_m;

  qrs_pkg::dv_t  last;
  qrs_pkg::root_t fr_p, fr_m;
  res_t          res_nxt, slot0_r, slot1_r;
  logic [1:0]    cnt_r;
  logic          push, pop;

  assign en       = (cnt_r != 2'd2);
  assign in_ready = en;

  qrs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .coef_a   (in_coef_a),
    .coef_b   (in_coef_b),
    .coef_c   (in_coef_c),
    .sq_o     (sq_chain[0])
  );

  for (genvar i = 0; i < qrs_pkg::SQ_CELLS; i++) begin : g_sq
    qrs_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .sq_i  (sq_chain[i]),
      .sq_o  (sq_chain[i+1])
    );
  end

  // numerators -b +/- s (or -c), magnitudes and signs
  always_comb begin
    nb_ext = {{(qrs_pkg::NUM_W-qrs_pkg::DEN_W)
               {sq_chain[qrs_pkg::SQ_CELLS].num_base[qrs_pkg::DEN_W-1]}},
              sq_chain[qrs_pkg::SQ_CELLS].num_base};
    np     = nb_ext + {2'b00, sq_chain[qrs_pkg::SQ_CELLS].root};
    nm     = nb_ext - {2'b00, sq_chain[qrs_pkg::SQ_CELLS].root};
    mag_p  = np[qrs_pkg::NUM_W-1] ? ({qrs_pkg::NUM_W{1'b0}} - np) : np;
    mag_m  = nm[qrs_pkg::NUM_W-1] ? ({qrs_pkg::NUM_W{1'b0}} - nm) : nm;

    prep_nxt        = '0;
    prep_nxt.valid  = sq_chain[qrs_pkg::SQ_CELLS].valid;
    prep_nxt.status = sq_chain[qrs_pkg::SQ_CELLS].status;
    prep_nxt.dm     = sq_chain[qrs_pkg::SQ_CELLS].den[qrs_pkg::DEN_W-1]
                    ? ({qrs_pkg::DEN_W{1'b0}} - sq_chain[qrs_pkg::SQ_CELLS].den)
                    : sq_chain[qrs_pkg::SQ_CELLS].den;
    prep_nxt.p.neg  = np[qrs_pkg::NUM_W-1]
                    ^ sq_chain[qrs_pkg::SQ_CELLS].den[qrs_pkg::DEN_W-1];
    prep_nxt.m.neg  = nm[qrs_pkg::NUM_W-1]
                    ^ sq_chain[qrs_pkg::SQ_CELLS].den[qrs_pkg::DEN_W-1];
    prep_nxt.p.nd   = qrs_pkg::DIVD_W'(mag_p[qrs_pkg::NUM_W-2:0]) << qrs_pkg::FRAC_BITS;
    prep_nxt.m.nd   = qrs_pkg::DIVD_W'(mag_m[qrs_pkg::NUM_W-2:0]) << qrs_pkg::FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.valid <= 1'b0;
    end else if (en) begin
      prep_r.valid <= prep_nxt.valid;
    end
    if (en) begin
      prep_r.status <= prep_nxt.status;
      prep_r.dm     <= prep_nxt.dm;
      prep_r.p      <= prep_nxt.p;
      prep_r.m      <= prep_nxt.m;
    end
  end

  assign dv_chain[0] = prep_r;

  for (genvar j = 0; j < qrs_pkg::DIV_CELLS; j++) begin : g_dv
    qrs_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .dv_i  (dv_chain[j]),
      .dv_o  (dv_chain[j+1])
    );
  end

  // sign, saturate, and drop the roots where there are none
  always_comb begin
    last = dv_chain[qrs_pkg::DIV_CELLS];
    fr_p = qrs_pkg::fmt_root(last.p);
    fr_m = qrs_pkg::fmt_root(last.m);
    res_nxt.status = last.status;
    if ((last.status == qrs_pkg::ST_NONE) || (last.status == qrs_pkg::ST_ERR)) begin
      res_nxt.rp  = '0;
      res_nxt.rm  = '0;
      res_nxt.ovf = 1'b0;
    end else begin
      res_nxt.rp  = fr_p.val;
      res_nxt.rm  = fr_m.val;
      res_nxt.ovf = fr_p.ovf | fr_m.ovf;
    end
  end

  assign push = last.valid && en;
  assign pop  = out_valid && out_ready;

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      case (cnt_r)
        2'd0: if (push) cnt_r <= 2'd1;
        2'd1: if (pop && !push) cnt_r <= 2'd0;
              else if (push && !pop) cnt_r <= 2'd2;
        2'd2: if (pop) cnt_r <= 2'd1;
        default: cnt_r <= 2'd0;
      endcase
    end
    case (cnt_r)
      2'd0: if (push) slot0_r <= res_nxt;
      2'd1: if (push && pop) slot0_r <= res_nxt;
            else if (push) slot1_r <= res_nxt;
      2'd2: if (pop) slot0_r <= slot1_r;
      default: ;
    endcase
  end

  assign out_valid      = (cnt_r != 2'd0);
  assign out_status     = slot0_r.status;
  assign out_root_plus  = slot0_r.rp;
  assign out_root_minus = slot0_r.rm;
  assign out_overflow   = slot0_r.ovf;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid)
    else $error("result pushed but buffer empty");

  a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == qrs_pkg::ST_NONE) || (out_status == qrs_pkg::ST_ERR))
    |-> (out_root_plus == '0) && (out_root_minus == '0) && !out_overflow)
    else $error("roots present without real roots");

  a_one_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == qrs_pkg::ST_ONE) |-> out_root_plus == out_root_minus)
    else $error("single root differs between outputs");

endmodule

`default_nettype wire
